FILE: sv/dpom_pkg.sv
// Package: shared constants, types and the air-quality grading helper of the meter.
package dpom_pkg;

    localparam int unsigned COUNTER_BITS_DEF = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [22:0] RATIO_MAX = 23'd6553600;
    localparam logic [18:0] MASS_MAX = 19'd344000;
    localparam logic [13:0] COUNT_MAX = 14'd12500;
    localparam logic [17:0] COEF_SQ = 18'd258425;
    localparam logic [23:0] COEF_LIN = 24'd8585210;
    localparam logic [20:0] COEF_OFS = 21'd1345549;
    localparam logic [18:0] ULTRAFINE_MEDIUM = 19'd150;
    localparam logic [9:0] COUNT_COEF = 10'd625;

    typedef enum logic [2:0] {
        CFG_WINDOW_TICKS = 3'd0,
        CFG_CO2_BAD = 3'd1,
        CFG_CO2_MEDIUM = 3'd2,
        CFG_TVOC_BAD = 3'd3,
        CFG_TVOC_MEDIUM = 3'd4,
        CFG_FINE_BAD = 3'd5,
        CFG_FINE_MEDIUM = 3'd6,
        CFG_ULTRAFINE_BAD = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        AQ_BAD = 2'd0,
        AQ_MEDIUM = 2'd1,
        AQ_GOOD = 2'd2
    } t_air_quality;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SQUARE,
        ST_MUL_SQ_LO,
        ST_MUL_SQ_HI,
        ST_MUL_LIN,
        ST_SUM,
        ST_MASS_DIV,
        ST_FINISH,
        ST_OUT
    } t_state;

    function automatic logic [1:0] grade(input logic [1:0] q, input logic [18:0] v,
                                         input logic [18:0] bad, input logic [18:0] med);
        logic [1:0] r;
        r = q;
        if (v > bad) begin
            r = AQ_BAD;
        end else if (v > med && q > AQ_MEDIUM) begin
            r = AQ_MEDIUM;
        end
        return r;
    endfunction

endpackage

FILE: sv/dpom_if.sv
// Interfaces: input tick channel and result channel with valid/ready handshake.
interface dpom_in_if;
    logic        valid;
    logic        ready;
    logic        fine_pin_level;
    logic        ultrafine_pin_level;
    logic [15:0] co2_ppm;
    logic [15:0] tvoc_ppb;
    modport source (output valid, fine_pin_level, ultrafine_pin_level, co2_ppm, tvoc_ppb,
                    input ready);
    modport sink (input valid, fine_pin_level, ultrafine_pin_level, co2_ppm, tvoc_ppb,
                  output ready);
endinterface

interface dpom_out_if;
    logic        valid;
    logic        ready;
    logic [22:0] fine_ratio;
    logic [22:0] ultrafine_ratio;
    logic [18:0] fine_mass;
    logic [18:0] ultrafine_mass;
    logic [13:0] fine_count;
    logic [13:0] ultrafine_count;
    logic [1:0]  air_quality;
    modport source (output valid, fine_ratio, ultrafine_ratio, fine_mass, ultrafine_mass,
                    fine_count, ultrafine_count, air_quality, input ready);
    modport sink (input valid, fine_ratio, ultrafine_ratio, fine_mass, ultrafine_mass,
                  fine_count, ultrafine_count, air_quality, output ready);
endinterface

FILE: sv/dust_pulse_occupancy_meter.sv
// Top level: dust pulse occupancy meter with bit-serial window-end arithmetic.
// Window end: a tick inside the window is absorbed in its accept cycle. A closing tick runs each
// channel, fine first and then ultrafine, through one shared datapath (restoring divide, square,
// multiplies and sum, mass divide, finish); the result beat is then loaded into the output
// register once it is free, ready low meanwhile.
// Throughput: one tick per cycle in a window. Reset (synchronous): state, configuration, tick tracking and valid.
module dust_pulse_occupancy_meter
    import dpom_pkg::*;
#(
    parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dpom_in_if.sink               in_ch,
    dpom_out_if.source            out_ch
);
    localparam int unsigned CB = COUNTER_BITS;
    // Dividend bits for ratio: total*100 then 16 fraction bits.
    localparam int unsigned NUM_W = CB + 7;
    localparam int unsigned DIV_STEPS = NUM_W + 16;
    localparam int unsigned STEP_W = $clog2(DIV_STEPS + 1);
    localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};

    // Configuration registers.
    logic [31:0] r_window_ticks;
    logic [15:0] r_co2_bad, r_co2_med, r_tvoc_bad, r_tvoc_med;
    logic [18:0] r_fine_bad, r_fine_med, r_uf_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_ticks <= 32'd10000000;
            r_co2_bad <= 16'd1000;
            r_co2_med <= 16'd800;
            r_tvoc_bad <= 16'd500;
            r_tvoc_med <= 16'd250;
            r_fine_bad <= 19'd600;
            r_fine_med <= 19'd300;
            r_uf_bad <= 19'd350;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WINDOW_TICKS:  r_window_ticks <= i_cfg_data;
                CFG_CO2_BAD:       r_co2_bad <= i_cfg_data[15:0];
                CFG_CO2_MEDIUM:    r_co2_med <= i_cfg_data[15:0];
                CFG_TVOC_BAD:      r_tvoc_bad <= i_cfg_data[15:0];
                CFG_TVOC_MEDIUM:   r_tvoc_med <= i_cfg_data[15:0];
                CFG_FINE_BAD:      r_fine_bad <= i_cfg_data[18:0];
                CFG_FINE_MEDIUM:   r_fine_med <= i_cfg_data[18:0];
                CFG_ULTRAFINE_BAD: r_uf_bad <= i_cfg_data[18:0];
            endcase
        end
    end

    // Effective window: zero means one tick, clip to 2^CB. Held CB+1 bits wide.
    logic [CB:0] win_eff;
    always_comb begin
        logic [32:0] w;
        w = {1'b0, r_window_ticks};
        if (w == 33'd0) w = 33'd1;
        if (CB < 32 && w > (33'd1 << CB)) w = 33'd1 << CB;
        win_eff = (CB + 1)'(w);
    end

    // Tick tracking state.
    logic [CB-1:0] r_wcnt, r_fpend, r_upend, r_ftot, r_utot;
    logic          r_fseen, r_useen;
    logic [1:0]    r_prev;
    logic [15:0]   r_co2, r_tvoc;

    t_state r_state, n_state;
    logic   accept;
    logic   out_free;
    // Take ticks whenever the arithmetic is idle; a waiting result sits in the output register.
    assign in_ch.ready = (r_state == ST_IDLE);
    assign accept = in_ch.valid && in_ch.ready;
    assign out_free = !out_ch.valid || out_ch.ready;

    function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] a);
        return (a == CNT_MAX) ? a : a + 1'b1;
    endfunction
    function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [CB-1:0] b);
        logic [CB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CB] ? CNT_MAX : s[CB-1:0];
    endfunction

    // Per-tick next values of both channels.
    logic [CB-1:0] n_fpend, n_upend, n_ftot, n_utot;
    logic          n_fseen, n_useen;
    always_comb begin
        logic [CB-1:0] p;
        p = '0;
        n_fseen = r_fseen; n_fpend = r_fpend; n_ftot = r_ftot;
        if (r_prev[0] && !in_ch.fine_pin_level) begin
            n_fseen = 1'b1; n_fpend = '0;
        end else if (r_fseen) begin
            p = sat_inc(r_fpend);
            n_fpend = p;
            if (in_ch.fine_pin_level && !r_prev[0]) begin
                n_ftot = sat_add(r_ftot, p); n_fseen = 1'b0; n_fpend = '0;
            end
        end
        n_useen = r_useen; n_upend = r_upend; n_utot = r_utot;
        if (r_prev[1] && !in_ch.ultrafine_pin_level) begin
            n_useen = 1'b1; n_upend = '0;
        end else if (r_useen) begin
            p = sat_inc(r_upend);
            n_upend = p;
            if (in_ch.ultrafine_pin_level && !r_prev[1]) begin
                n_utot = sat_add(r_utot, p); n_useen = 1'b0; n_upend = '0;
            end
        end
    end

    logic close_win;
    assign close_win = ({1'b0, r_wcnt} + 1'b1) >= win_eff;

    // Shared datapath registers.
    logic              r_ch;          // 0 fine, 1 ultrafine
    logic [CB-1:0]     r_tot_sel;
    logic [NUM_W-1:0]  r_num;         // dividend shifted out MSB first
    logic [CB:0]       r_rem;
    logic [NUM_W+15:0] r_quo;
    logic [STEP_W-1:0] r_step;
    logic [22:0]       r_ratio;
    logic [45:0]       r_sq;
    logic [63:0]       r_acc;
    logic [18:0]       r_mass;
    logic [22:0]       r_fr, r_ur;
    logic [18:0]       r_fm;

    // Restoring-divide step.
    logic [CB+1:0] div_trial;
    assign div_trial = {r_rem, r_num[NUM_W-1]} - {1'b0, win_eff};

    // Mass division: (acc - ofs) / (10000<<32) reduced to acc_hi / 10000, 32 steps.
    logic [14:0] mdiv_trial;
    logic [13:0] r_mrem;
    logic [31:0] r_mq;
    logic [31:0] r_mnum;
    assign mdiv_trial = {r_mrem, r_mnum[31]} - 15'd10000;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (accept && close_win) n_state = ST_DIVIDE;
            ST_DIVIDE:    if (r_step == STEP_W'(DIV_STEPS - 1)) n_state = ST_SQUARE;
            ST_SQUARE:    n_state = ST_MUL_SQ_LO;
            ST_MUL_SQ_LO: n_state = ST_MUL_SQ_HI;
            ST_MUL_SQ_HI: n_state = ST_MUL_LIN;
            ST_MUL_LIN:   n_state = ST_SUM;
            ST_SUM:       n_state = ST_MASS_DIV;
            ST_MASS_DIV:  if (r_step == STEP_W'(32)) n_state = ST_FINISH;
            ST_FINISH:    n_state = r_ch ? ST_OUT : ST_DIVIDE;
            // Hold the reading until the output register is free.
            ST_OUT:       if (out_free) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    logic [63:0] ofs64;
    assign ofs64 = {11'd0, COEF_OFS, 32'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt <= '0; r_fseen <= 1'b0; r_useen <= 1'b0;
            r_fpend <= '0; r_upend <= '0; r_ftot <= '0; r_utot <= '0;
            r_prev <= 2'b11; r_ch <= 1'b0; r_step <= '0;
            out_ch.valid <= 1'b0;
        end else begin
            // Load a new beat when free, drop valid once the beat is taken.
            if (r_state == ST_OUT && out_free) out_ch.valid <= 1'b1;
            else if (out_ch.ready) out_ch.valid <= 1'b0;
            if (accept) begin
                // Advance edge tracking, then the window counter.
                r_fseen <= n_fseen; r_fpend <= n_fpend; r_ftot <= n_ftot;
                r_useen <= n_useen; r_upend <= n_upend; r_utot <= n_utot;
                r_prev <= {in_ch.ultrafine_pin_level, in_ch.fine_pin_level};
                r_co2 <= in_ch.co2_ppm; r_tvoc <= in_ch.tvoc_ppb;
                if (close_win) begin
                    r_wcnt <= '0;
                    r_ch <= 1'b0;
                    r_tot_sel <= n_ftot;
                    r_step <= '0;
                    r_rem <= '0;
                    // total*100 = total*64 + total*32 + total*4
                    r_num <= NUM_W'({n_ftot, 6'd0} + {n_ftot, 5'd0} + {n_ftot, 2'd0});
                end else begin
                    r_wcnt <= r_wcnt + 1'b1;
                end
            end
            unique case (r_state)
                ST_DIVIDE: begin
                    // One quotient bit a cycle; dividend bits then zeros.
                    if (!div_trial[CB+1]) begin
                        r_rem <= div_trial[CB:0];
                        r_quo <= {r_quo[NUM_W+14:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[CB-1:0], r_num[NUM_W-1]};
                        r_quo <= {r_quo[NUM_W+14:0], 1'b0};
                    end
                    r_num <= {r_num[NUM_W-2:0], 1'b0};
                    r_step <= (r_step == STEP_W'(DIV_STEPS - 1)) ? '0 : r_step + 1'b1;
                end
                ST_SQUARE: begin
                    if ({1'b0, r_tot_sel} >= win_eff) r_ratio <= RATIO_MAX;
                    else r_ratio <= 23'(r_quo);
                end
                ST_MUL_SQ_LO: r_sq <= {23'd0, r_ratio} * {23'd0, r_ratio};
                ST_MUL_SQ_HI: r_acc <= 64'(r_sq * {28'd0, COEF_SQ});
                ST_MUL_LIN: r_sq <= 46'({23'd0, r_ratio} * {22'd0, COEF_LIN});
                ST_SUM: begin
                    r_acc <= (r_acc + {2'd0, r_sq, 16'd0} > ofs64) ?
                             r_acc + {2'd0, r_sq, 16'd0} - ofs64 : 64'd0;
                    r_mnum <= '0;
                    r_mrem <= '0;
                    r_step <= '0;
                end
                ST_MASS_DIV: begin
                    if (r_step == '0) begin
                        r_mnum <= r_acc[63:32];
                        r_mq <= '0;
                        r_step <= r_step + 1'b1;
                    end else begin
                        if (!mdiv_trial[14]) begin
                            r_mrem <= mdiv_trial[13:0];
                            r_mq <= {r_mq[30:0], 1'b1};
                        end else begin
                            r_mrem <= {r_mrem[12:0], r_mnum[31]};
                            r_mq <= {r_mq[30:0], 1'b0};
                        end
                        r_mnum <= {r_mnum[30:0], 1'b0};
                        r_step <= (r_step == STEP_W'(32)) ? '0 : r_step + 1'b1;
                    end
                end
                ST_FINISH: begin
                    r_mass <= (r_mq > {13'd0, MASS_MAX}) ? MASS_MAX : r_mq[18:0];
                    if (!r_ch) begin
                        r_fr <= r_ratio;
                        r_fm <= (r_mq > {13'd0, MASS_MAX}) ? MASS_MAX : r_mq[18:0];
                        r_ch <= 1'b1;
                        r_tot_sel <= r_utot;
                        r_rem <= '0;
                        r_step <= '0;
                        r_num <= NUM_W'({r_utot, 6'd0} + {r_utot, 5'd0} + {r_utot, 2'd0});
                    end else begin
                        r_ur <= r_ratio;
                    end
                end
                ST_OUT: begin
                    r_ftot <= '0;
                    r_utot <= '0;
                end
                default: ;
            endcase
        end
    end

    // Result register fields.
    function automatic logic [13:0] count_of(input logic [22:0] r);
        logic [32:0] c;
        c = {10'd0, r} * {23'd0, COUNT_COEF};
        return (c[32:16] > {3'd0, COUNT_MAX}) ? COUNT_MAX : c[29:16];
    endfunction

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            out_ch.fine_ratio <= r_fr;
            out_ch.ultrafine_ratio <= r_ur;
            out_ch.fine_mass <= r_fm;
            out_ch.ultrafine_mass <= r_mass;
            out_ch.fine_count <= count_of(r_fr);
            out_ch.ultrafine_count <= count_of(r_ur);
            out_ch.air_quality <= grade(grade(grade(grade(AQ_GOOD, {3'd0, r_co2},
                {3'd0, r_co2_bad}, {3'd0, r_co2_med}), {3'd0, r_tvoc},
                {3'd0, r_tvoc_bad}, {3'd0, r_tvoc_med}), r_fm, r_fine_bad, r_fine_med),
                r_mass, r_uf_bad, ULTRAFINE_MEDIUM);
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
    a_out_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_ch.valid) |-> $past(r_state == ST_OUT)) else $error("stray result");
    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> (out_ch.fine_ratio <= RATIO_MAX && out_ch.air_quality <= AQ_GOOD))
        else $error("result out of range");
`endif
endmodule
